>>> rtl/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and fixed-point helpers of the pressure sampler.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int AdcBits = 16;
  localparam logic [15:0] AdcMask = 16'((32'd1 << AdcBits) - 32'd1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgMode       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetPsi  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAdcOffset  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainQ24    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFilterEn   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMonIntvl   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCtlIntvl   = 3'd6;

  // Operating modes.
  localparam logic [1:0] ModeOff     = 2'd0;
  localparam logic [1:0] ModeMonitor = 2'd1;
  localparam logic [1:0] ModeControl = 2'd2;

  localparam logic [31:0] MonIntvlReset = 32'd10000;
  localparam logic [31:0] CtlIntvlReset = 32'd1000;

  // Filter coefficient 0.3 in Q16.
  localparam logic signed [32:0] AlphaQ16 = 33'sd19661;

  localparam int MulAW = 25;
  localparam int MulBW = 33;
  localparam int MulPW = MulAW + MulBW;
  localparam int RndW  = 42;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  target_psi;
    logic [15:0] adc_offset;
    logic [31:0] gain_q24;
    logic        filter_enable;
    logic [31:0] monitor_interval_ms;
    logic [31:0] control_interval_ms;
  } cfg_t;

  // Divide by 65536, rounding to nearest with ties away from zero.
  function automatic logic signed [RndW-1:0] round_shift16(
    input logic signed [MulPW-1:0] x
  );
    logic [MulPW-1:0] mag;
    logic [MulPW-1:0] r;
    mag = x[MulPW-1] ? MulPW'(-x) : MulPW'(x);
    r   = (mag + MulPW'(32768)) >> 16;
    return x[MulPW-1] ? -$signed(r[RndW-1:0]) : $signed(r[RndW-1:0]);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [RndW-1:0] v);
    if (v > 42'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -42'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

>>> rtl/psc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_in_if
// Input channel: one sample request item per handshake.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [15:0] adc_count;
  logic        cap_enabled;

  modport source (output valid, now_ms, adc_count, cap_enabled, input ready);
  modport sink   (input valid, now_ms, adc_count, cap_enabled, output ready);
endinterface

>>> rtl/psc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_out_if
// Output channel: one result item per input item.
// ----------------------------------------------------------------------------
interface psc_out_if;
  logic               valid;
  logic               ready;
  logic               sample_taken;
  logic signed [23:0] pressure_q8;
  logic               cap_command_valid;
  logic               cap_close;

  modport source (output valid, sample_taken, pressure_q8, cap_command_valid, cap_close,
                  input ready);
  modport sink   (input valid, sample_taken, pressure_q8, cap_command_valid, cap_close,
                  output ready);
endinterface

>>> rtl/psc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module psc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [psc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output psc_pkg::cfg_t                  cfg_o
);
  import psc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode                <= ModeOff;
      cfg_q.target_psi          <= '0;
      cfg_q.adc_offset          <= '0;
      cfg_q.gain_q24            <= '0;
      cfg_q.filter_enable       <= 1'b1;
      cfg_q.monitor_interval_ms <= MonIntvlReset;
      cfg_q.control_interval_ms <= CtlIntvlReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:      cfg_q.mode                <= cfg_wdata_i[1:0];
        CfgTargetPsi: cfg_q.target_psi          <= cfg_wdata_i[7:0];
        CfgAdcOffset: cfg_q.adc_offset          <= cfg_wdata_i[15:0];
        CfgGainQ24:   cfg_q.gain_q24            <= cfg_wdata_i;
        CfgFilterEn:  cfg_q.filter_enable       <= cfg_wdata_i[0];
        CfgMonIntvl:  cfg_q.monitor_interval_ms <= cfg_wdata_i;
        CfgCtlIntvl:  cfg_q.control_interval_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/psc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_mul
// Shared signed multiplier with a registered product, used for both the
// count-to-pressure scaling and the filter step.
// ----------------------------------------------------------------------------
module psc_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [psc_pkg::MulAW-1:0]    a_i,
  input  logic signed [psc_pkg::MulBW-1:0]    b_i,
  output logic signed [psc_pkg::MulPW-1:0]    prod_o
);
  import psc_pkg::*;

  logic signed [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= MulPW'(a_i) * MulPW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/pressure_sampler_cap_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sampler_cap_control
// Periodic pressure sampler: scales an ADC count to Q8 psi, optionally
// smooths it with a 0.3 exponential filter and issues cap open/close
// commands in control mode.
// ----------------------------------------------------------------------------
//   channel   direction  handshake        payload
//   in_ch     sink       valid / ready    now_ms, adc_count, cap_enabled
//   out_ch    source     valid / ready    sample_taken, pressure_q8,
//                                         cap_command_valid, cap_close
//   cfg       write      cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// An item that takes no sample goes from the decide step to the finish step; a
// sample passes the scaling multiply and round steps and, when filtered, the
// filter multiply and round steps, run one after the other through one multiplier.
// The input is ready only while the sequencer is idle; a finished result
// waits in the output register, and the next item may be accepted then.
// Reset is asynchronous and active low; it clears state and returns configuration to its reset values.
// ----------------------------------------------------------------------------
module pressure_sampler_cap_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  psc_in_if.sink                         in_ch,
  psc_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [psc_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import psc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StMulScale,
    StRndScale,
    StMulFilt,
    StRndFilt,
    StFinish
  } state_e;

  cfg_t cfg;

  state_e             state_q;
  logic [31:0]        now_q;
  logic [15:0]        count_q;
  logic               cap_en_q;
  logic               sample_q;
  logic [31:0]        last_ms_q;
  logic signed [23:0] filt_q;
  logic signed [23:0] press_q;

  logic               out_valid_q;
  logic               out_sample_q;
  logic signed [23:0] out_press_q;
  logic               out_cmd_q;
  logic               out_close_q;

  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  logic [31:0]             elapsed;
  logic                    take_sample;
  logic signed [16:0]      diff;
  logic signed [RndW-1:0]  filt_sum;
  logic                    cmd;
  logic                    close_cap;
  logic                    out_free;

  psc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign elapsed     = now_q - last_ms_q;
  assign take_sample = ((cfg.mode == ModeMonitor) && (elapsed > cfg.monitor_interval_ms)) ||
                       ((cfg.mode == ModeControl) && (elapsed > cfg.control_interval_ms));
  assign diff        = $signed({1'b0, count_q}) - $signed({1'b0, cfg.adc_offset});

  // The multiplier operands follow the step the sequencer is in.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = MulAW'(diff);
    mul_b  = $signed({1'b0, cfg.gain_q24});
    case (state_q)
      StMulScale: begin
        mul_en = 1'b1;
      end
      StMulFilt: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(press_q) - MulAW'(filt_q);
        mul_b  = AlphaQ16;
      end
      default: ;
    endcase
  end

  assign filt_sum  = RndW'(filt_q) + round_shift16(prod);
  assign cmd       = sample_q && (cfg.mode == ModeControl) && (filt_q > 24'sd0) &&
                     cap_en_q && (cfg.target_psi != 8'd0);
  assign close_cap = cmd && !(25'(filt_q) > $signed({1'b0, cfg.target_psi, 8'd0}));
  assign out_free  = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      now_q        <= '0;
      count_q      <= '0;
      cap_en_q     <= 1'b0;
      sample_q     <= 1'b0;
      last_ms_q    <= '0;
      filt_q       <= '0;
      press_q      <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= 1'b0;
      out_press_q  <= '0;
      out_cmd_q    <= 1'b0;
      out_close_q  <= 1'b0;
    end else begin
      // In the finish step the output register is reloaded instead.
      if (out_valid_q && out_ch.ready && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_ch.valid) begin
            now_q    <= in_ch.now_ms;
            count_q  <= in_ch.adc_count & AdcMask;
            cap_en_q <= in_ch.cap_enabled;
            state_q  <= StDecide;
          end
        end
        StDecide: begin
          sample_q <= take_sample;
          state_q  <= take_sample ? StMulScale : StFinish;
        end
        StMulScale: begin
          state_q <= StRndScale;
        end
        StRndScale: begin
          last_ms_q <= now_q;
          if (cfg.filter_enable) begin
            press_q <= sat24(round_shift16(prod));
            state_q <= StMulFilt;
          end else begin
            filt_q  <= sat24(round_shift16(prod));
            state_q <= StFinish;
          end
        end
        StMulFilt: begin
          state_q <= StRndFilt;
        end
        StRndFilt: begin
          filt_q  <= sat24(filt_sum);
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= sample_q;
            out_press_q  <= filt_q;
            out_cmd_q    <= cmd;
            out_close_q  <= close_cap;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ch.ready              = (state_q == StIdle);
  assign out_ch.valid             = out_valid_q;
  assign out_ch.sample_taken      = out_sample_q;
  assign out_ch.pressure_q8       = out_press_q;
  assign out_ch.cap_command_valid = out_cmd_q;
  assign out_ch.cap_close         = out_close_q;

endmodule
